/* hw/rtl/dbc_pkg.sv */
// Shared types, widths and register map for the distortion / bitcrusher chain.
// No dependencies; imported by dbc_front, dbc_back and the top level.
`timescale 1ns / 1ps

package dbc_pkg;

    // Data path widths
    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 8;
    localparam int THR_W    = 15;
    localparam int HOLD_W   = 8;
    localparam int DEPTH_W  = 5;

    // Queue between front and back
    localparam int FIFO_DEPTH_DEF = 4;

    // Configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // Register indexes (byte address = 4 * index)
    typedef enum logic [REG_IDX_W-1:0] {
        REG_DIST_ENABLE    = 3'd0,
        REG_DIST_GAIN      = 3'd1,
        REG_DIST_THRESHOLD = 3'd2,
        REG_CRUSH_ENABLE   = 3'd3,
        REG_HOLD_COUNT     = 3'd4,
        REG_CRUSH_DEPTH    = 3'd5
    } reg_idx_t;

    // Reset values
    localparam logic [GAIN_W-1:0]  DIST_GAIN_RST      = GAIN_W'(1);
    localparam logic [THR_W-1:0]   DIST_THRESHOLD_RST = {THR_W{1'b1}};
    localparam logic [HOLD_W-1:0]  HOLD_COUNT_RST     = HOLD_W'(1);
    localparam logic [DEPTH_W-1:0] CRUSH_DEPTH_RST    = DEPTH_W'(SAMPLE_W);

    // Distortion settings seen by the front
    typedef struct packed {
        logic              enable;
        logic [GAIN_W-1:0] gain;
        logic [THR_W-1:0]  threshold;
    } dist_cfg_t;

    // Bitcrusher settings seen by the back
    typedef struct packed {
        logic               enable;
        logic [HOLD_W-1:0]  hold_count;
        logic [DEPTH_W-1:0] kept_bits;
    } crush_cfg_t;

endpackage

/* hw/rtl/dbc_fifo.sv */
// Short register queue between the distortion front and the bitcrusher back.
// Depends on nothing; width and depth come from parameters.
`timescale 1ns / 1ps

module dbc_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Advance pointers with wrap at the last entry
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hw/rtl/dbc_front.sv */
// Front part: accepts samples, applies gain and hard clipping when enabled, feeds the queue.
// Depends on dbc_pkg.
`timescale 1ns / 1ps

module dbc_front
    import dbc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dist_cfg_t           dist_cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SAMPLE_W-1:0] in_data,
    output logic                q_push,
    output logic [SAMPLE_W-1:0] q_data,
    input  logic                q_full
);

    logic [SAMPLE_W+GAIN_W-1:0] prod_full;
    logic                       s1_valid_reg, s1_valid_next;
    logic                       s1_clip_reg;
    logic [SAMPLE_W-1:0]        s1_data_reg;
    logic signed [SAMPLE_W:0]   y_ext;
    logic signed [SAMPLE_W:0]   th_pos;
    logic signed [SAMPLE_W:0]   th_neg;
    logic                       take;

    // Gain product; only the low 16 bits matter after wrap
    assign prod_full = {{GAIN_W{1'b0}}, in_data} * {{SAMPLE_W{1'b0}}, dist_cfg.gain};

    assign q_push   = s1_valid_reg && !q_full;
    assign in_ready = !s1_valid_reg || q_push;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Capture wrapped product or bypass sample
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_clip_reg <= dist_cfg.enable;
            s1_data_reg <= dist_cfg.enable ? prod_full[SAMPLE_W-1:0] : in_data;
        end
    end

    // Clamp to +/- threshold
    assign y_ext  = {s1_data_reg[SAMPLE_W-1], s1_data_reg};
    assign th_pos = {2'b00, dist_cfg.threshold};
    assign th_neg = -th_pos;

    always_comb
    begin
        q_data = s1_data_reg;
        if (s1_clip_reg)
        begin
            if (y_ext > th_pos)
            begin
                q_data = th_pos[SAMPLE_W-1:0];
            end
            else if (y_ext < th_neg)
            begin
                q_data = th_neg[SAMPLE_W-1:0];
            end
        end
    end

endmodule

/* hw/rtl/dbc_back.sv */
// Back part: sample hold and bit depth reduction when enabled, drives the output register.
// Depends on dbc_pkg.
`timescale 1ns / 1ps

module dbc_back
    import dbc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  crush_cfg_t          crush_cfg,
    input  logic                q_empty,
    input  logic [SAMPLE_W-1:0] q_data,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SAMPLE_W-1:0] out_sample
);

    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] out_data_reg;
    logic [HOLD_W-1:0]   hold_counter_reg, hold_counter_next;
    logic [SAMPLE_W-1:0] held_sample_reg, held_sample_next;
    logic [HOLD_W-1:0]   cnt_inc;
    logic [SAMPLE_W-1:0] keep_mask;
    logic [SAMPLE_W-1:0] result;

    assign q_pop      = !q_empty && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_sample = out_data_reg;

    // Low bits to clear: all ones shifted right by the kept depth
    assign keep_mask = ~({SAMPLE_W{1'b1}} >> crush_cfg.kept_bits);
    assign cnt_inc   = hold_counter_reg + 1'b1;

    // Repeat held sample until the counter reaches the hold setting
    always_comb
    begin
        hold_counter_next = hold_counter_reg;
        held_sample_next  = held_sample_reg;
        result            = q_data;
        if (crush_cfg.enable)
        begin
            if (cnt_inc < crush_cfg.hold_count)
            begin
                hold_counter_next = cnt_inc;
                result            = held_sample_reg;
            end
            else
            begin
                hold_counter_next = '0;
                result            = q_data & keep_mask;
                held_sample_next  = result;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (q_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            hold_counter_reg <= '0;
            held_sample_reg  <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                hold_counter_reg <= hold_counter_next;
                held_sample_reg  <= held_sample_next;
            end
        end
    end

    // Load output payload on each transfer out of the queue
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_data_reg <= result;
        end
    end

endmodule

/* hw/rtl/distortion_bitcrusher_chain_top.sv */
// Top level of the distortion / bitcrusher chain: register file and wiring.
// Depends on dbc_pkg, dbc_front, dbc_fifo, dbc_back.
//
//   channel   direction  handshake                 payload
//   s_axis    in         s_tvalid / s_tready       s_tdata[15:0] = sample_in
//   m_axis    out        m_tvalid / m_tready       m_tdata[15:0] = sample_out
//   apb       in         psel, penable, pready     paddr[4:2] = register, pwdata
//
// One sample per cycle sustained while m_tready is high; the result is offered
// on m_tvalid once the input transfer has passed the gain register (loaded at
// the transfer), the queue entry and the output register.
// rst_n clears all handshake state, the hold counter, the held sample and the
// registers to their defaults. The front and back stall independently: the
// queue of FIFO_DEPTH entries absorbs output stalls before s_tready drops.
`timescale 1ns / 1ps

module distortion_bitcrusher_chain_top
    import dbc_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,   // [15:0] sample_in
    // Output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [SAMPLE_W-1:0]   m_tdata,   // [15:0] sample_out
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    dist_cfg_t           dist_cfg_reg;
    crush_cfg_t          crush_cfg_reg;
    reg_idx_t            reg_idx;
    logic                wr_en;
    logic                q_push;
    logic                q_pop;
    logic                q_full;
    logic                q_empty;
    logic [SAMPLE_W-1:0] q_wdata;
    logic [SAMPLE_W-1:0] q_rdata;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_cfg_reg.enable      <= 1'b0;
            dist_cfg_reg.gain        <= DIST_GAIN_RST;
            dist_cfg_reg.threshold   <= DIST_THRESHOLD_RST;
            crush_cfg_reg.enable     <= 1'b0;
            crush_cfg_reg.hold_count <= HOLD_COUNT_RST;
            crush_cfg_reg.kept_bits  <= CRUSH_DEPTH_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_DIST_ENABLE:    dist_cfg_reg.enable      <= pwdata[0];
                REG_DIST_GAIN:      dist_cfg_reg.gain        <= pwdata[GAIN_W-1:0];
                REG_DIST_THRESHOLD: dist_cfg_reg.threshold   <= pwdata[THR_W-1:0];
                REG_CRUSH_ENABLE:   crush_cfg_reg.enable     <= pwdata[0];
                REG_HOLD_COUNT:     crush_cfg_reg.hold_count <= pwdata[HOLD_W-1:0];
                REG_CRUSH_DEPTH:    crush_cfg_reg.kept_bits  <= pwdata[DEPTH_W-1:0];
                default:            ;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        case (reg_idx)
            REG_DIST_ENABLE:    prdata = APB_DATA_W'(dist_cfg_reg.enable);
            REG_DIST_GAIN:      prdata = APB_DATA_W'(dist_cfg_reg.gain);
            REG_DIST_THRESHOLD: prdata = APB_DATA_W'(dist_cfg_reg.threshold);
            REG_CRUSH_ENABLE:   prdata = APB_DATA_W'(crush_cfg_reg.enable);
            REG_HOLD_COUNT:     prdata = APB_DATA_W'(crush_cfg_reg.hold_count);
            REG_CRUSH_DEPTH:    prdata = APB_DATA_W'(crush_cfg_reg.kept_bits);
            default:            prdata = '0;
        endcase
    end

    dbc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .dist_cfg  (dist_cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .q_push    (q_push),
        .q_data    (q_wdata),
        .q_full    (q_full)
    );

    dbc_fifo #(
        .WIDTH (SAMPLE_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    dbc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .crush_cfg  (crush_cfg_reg),
        .q_empty    (q_empty),
        .q_data     (q_rdata),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_sample (m_tdata)
    );

endmodule
